// ===== hdl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// shared widths and limits for the burnt pancake sorter
// ----------------------------------------------------------------------------
package bps_pkg;

   // stack depth and derived index widths
   localparam int MAX_DEPTH = 16;
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int HGT_W     = $clog2(MAX_DEPTH + 1);

   // pancake value and move counter widths
   localparam int VAL_W  = 16;
   localparam int MAG_W  = VAL_W - 1;
   localparam int MOVE_W = 8;

   localparam logic [MOVE_W-1:0] MOVE_LIMIT = '1;
   localparam logic [VAL_W-1:0]  VAL_MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W-1:0]  VAL_LEAST_NEG_SAFE = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

endpackage

// ===== hdl/burnt_pancake_sorter.sv =====
// ----------------------------------------------------------------------------
// burnt_pancake_sorter
// loads a stack of signed pancakes and sorts it by negating prefix flips
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  req       in         start && !busy             req_pancake_value, req_is_final
//  rsp       out        rsp_valid, one cycle each  rsp_sorted_value, rsp_move_total,
//                                                  rsp_is_final_out
//
//  a non-final item is stored (dropped once the stack is full) and busy stays low
//  the sort runs on the single-write-port stack memory through one shared
//  negate unit: a scan reads, then compares each entry in turn; a flip reads
//  an entry pair, then writes the low and then the high entry, one pair per
//  pass (the middle entry of an odd count takes a pass of its own); a negate
//  reads the top entry, then writes it back; each emitted entry is read, then sent
//  reset clears the sequencer, stack height and move count; stack contents
//  stay undefined until loaded
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module burnt_pancake_sorter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [bps_pkg::VAL_W-1:0]   req_pancake_value,
   input  logic                        req_is_final,
   output logic                        rsp_valid,
   output logic [bps_pkg::VAL_W-1:0]   rsp_sorted_value,
   output logic [bps_pkg::MOVE_W-1:0]  rsp_move_total,
   output logic                        rsp_is_final_out
);
   import bps_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PLACE_TOP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_PLACE_DEC,
      S_PLACE_NEG,
      S_PLACE_FLIP,
      S_PLACE_NEXT,
      S_ORIENT_TOP,
      S_ORIENT_CHK,
      S_ORIENT_NEG,
      S_ORIENT_FLIP,
      S_ORIENT_NEXT,
      S_FINISH,
      S_FLIP_RD,
      S_FLIP_W1,
      S_FLIP_W2,
      S_NEG_RD,
      S_NEG_W,
      S_OUT_RD,
      S_OUT_SEND
   } state_type;

   typedef enum logic [1:0] {
      NEG_ALWAYS,
      NEG_IF_POS,
      NEG_IF_NEG
   } neg_mode_type;

   // stack memory and its registered read ports
   logic signed [VAL_W-1:0] stack_mem [MAX_DEPTH];
   logic signed [VAL_W-1:0] rd_a_ff;
   logic signed [VAL_W-1:0] rd_b_ff;

   state_type               state_ff,   state_in;
   state_type               ret_ff,     ret_in;
   neg_mode_type            neg_mode_ff, neg_mode_in;
   logic [HGT_W-1:0]        height_ff,  height_in;
   logic [HGT_W-1:0]        h_ff,       h_in;
   logic [IDX_W-1:0]        idx_ff,     idx_in;
   logic [IDX_W-1:0]        best_ff,    best_in;
   logic [MAG_W-1:0]        best_mag_ff, best_mag_in;
   logic [IDX_W-1:0]        lo_ff,      lo_in;
   logic [IDX_W-1:0]        hi_ff,      hi_in;
   logic [MOVE_W-1:0]       moves_ff,   moves_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [MOVE_W-1:0]       rsp_moves_ff, rsp_moves_in;
   logic                    rsp_final_ff, rsp_final_in;

   logic                    accept;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr_a;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [VAL_W-1:0] wr_data;
   logic signed [VAL_W-1:0] neg_in;
   logic signed [VAL_W-1:0] neg_out;
   logic [MAG_W-1:0]        mag_a;
   logic                    neg_go;
   logic [HGT_W-1:0]        h_last;
   logic [VAL_W-1:0]        load_value;
   logic [MOVE_W-1:0]       moves_inc;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // shared negate unit, also used for the magnitude in the scan
   assign neg_in  = (state_ff == S_FLIP_W1) ? rd_b_ff : rd_a_ff;
   assign neg_out = -neg_in;
   assign mag_a   = rd_a_ff[VAL_W-1] ? neg_out[MAG_W-1:0] : rd_a_ff[MAG_W-1:0];

   assign h_last    = h_ff - HGT_W'(1);
   assign moves_inc = (moves_ff != MOVE_LIMIT) ? moves_ff + MOVE_W'(1) : moves_ff;

   // clamp the most negative code so every negation stays in range
   assign load_value = (req_pancake_value == VAL_MOST_NEG) ? VAL_LEAST_NEG_SAFE
                                                           : req_pancake_value;

   // conditional negate of the top entry
   always_comb begin
      case (neg_mode_ff)
         NEG_ALWAYS: neg_go = 1'b1;
         NEG_IF_POS: neg_go = !rd_a_ff[VAL_W-1] && (rd_a_ff != '0);
         NEG_IF_NEG: neg_go = rd_a_ff[VAL_W-1];
         default:    neg_go = 1'b0;
      endcase
   end

   // read address select
   always_comb begin
      rd_en     = 1'b1;
      rd_addr_a = '0;
      case (state_ff)
         S_SRCH_RD:    rd_addr_a = idx_ff;
         S_FLIP_RD:    rd_addr_a = lo_ff;
         S_NEG_RD:     rd_addr_a = '0;
         S_ORIENT_TOP: rd_addr_a = h_ff[IDX_W-1:0];
         S_OUT_RD:     rd_addr_a = idx_ff;
         default:      rd_en     = 1'b0;
      endcase
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = neg_out;
      case (state_ff)
         S_IDLE: begin
            wr_en   = accept && (height_ff < HGT_W'(MAX_DEPTH));
            wr_addr = height_ff[IDX_W-1:0];
            wr_data = load_value;
         end
         S_FLIP_W1: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
         end
         S_FLIP_W2: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
         end
         S_NEG_W: begin
            wr_en   = neg_go;
            wr_addr = '0;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= stack_mem[rd_addr_a];
         rd_b_ff <= stack_mem[hi_ff];
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      neg_mode_in  = neg_mode_ff;
      height_in    = height_ff;
      h_in         = h_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_mag_in  = best_mag_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      moves_in     = moves_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_moves_in = rsp_moves_ff;
      rsp_final_in = rsp_final_ff;
      case (state_ff)
         // load one entry per transfer while the stack has room
         S_IDLE: begin
            if (accept) begin
               if (height_ff < HGT_W'(MAX_DEPTH)) begin
                  height_in = height_ff + HGT_W'(1);
               end
               if (req_is_final) begin
                  moves_in = '0;
                  h_in     = (height_ff < HGT_W'(MAX_DEPTH)) ? height_ff + HGT_W'(1)
                                                              : height_ff;
                  state_in = S_PLACE_TOP;
               end
            end
         end
         // placing phase: scan the top h entries for the deepest largest
         S_PLACE_TOP: begin
            if (h_ff > HGT_W'(1)) begin
               idx_in   = '0;
               state_in = S_SRCH_RD;
            end else begin
               h_in     = height_ff - HGT_W'(1);
               state_in = S_ORIENT_TOP;
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if ((idx_ff == '0) || (best_mag_ff <= mag_a)) begin
               best_in     = idx_ff;
               best_mag_in = mag_a;
            end
            if (HGT_W'(idx_ff) == h_last) begin
               state_in = S_PLACE_DEC;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SRCH_RD;
            end
         end
         S_PLACE_DEC: begin
            if (HGT_W'(best_ff) == h_last) begin
               state_in = S_PLACE_NEXT;
            end else if (best_ff != '0) begin
               lo_in    = '0;
               hi_in    = best_ff;
               ret_in   = S_PLACE_NEG;
               state_in = S_FLIP_RD;
            end else begin
               state_in = S_PLACE_NEG;
            end
         end
         S_PLACE_NEG: begin
            neg_mode_in = NEG_IF_POS;
            ret_in      = S_PLACE_FLIP;
            state_in    = S_NEG_RD;
         end
         S_PLACE_FLIP: begin
            lo_in    = '0;
            hi_in    = h_last[IDX_W-1:0];
            ret_in   = S_PLACE_NEXT;
            state_in = S_FLIP_RD;
         end
         S_PLACE_NEXT: begin
            h_in     = h_last;
            state_in = S_PLACE_TOP;
         end
         // orientation phase: fix each burnt-side-up entry below the top
         S_ORIENT_TOP: begin
            if (h_ff != '0) begin
               state_in = S_ORIENT_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ORIENT_CHK: begin
            if (rd_a_ff[VAL_W-1]) begin
               lo_in    = '0;
               hi_in    = h_ff[IDX_W-1:0];
               ret_in   = S_ORIENT_NEG;
               state_in = S_FLIP_RD;
            end else begin
               state_in = S_ORIENT_NEXT;
            end
         end
         S_ORIENT_NEG: begin
            neg_mode_in = NEG_ALWAYS;
            ret_in      = S_ORIENT_FLIP;
            state_in    = S_NEG_RD;
         end
         S_ORIENT_FLIP: begin
            lo_in    = '0;
            hi_in    = h_ff[IDX_W-1:0];
            ret_in   = S_ORIENT_NEXT;
            state_in = S_FLIP_RD;
         end
         S_ORIENT_NEXT: begin
            h_in     = h_last;
            state_in = S_ORIENT_TOP;
         end
         // finish: fix the top entry
         S_FINISH: begin
            neg_mode_in = NEG_IF_NEG;
            ret_in      = S_OUT_RD;
            idx_in      = '0;
            state_in    = S_NEG_RD;
         end
         // flip: swap and negate one pair per pass, outside in
         S_FLIP_RD: state_in = S_FLIP_W1;
         S_FLIP_W1: state_in = S_FLIP_W2;
         S_FLIP_W2: begin
            if ((hi_ff - lo_ff) >= IDX_W'(2)) begin
               lo_in    = lo_ff + IDX_W'(1);
               hi_in    = hi_ff - IDX_W'(1);
               state_in = S_FLIP_RD;
            end else begin
               moves_in = moves_inc;
               state_in = ret_ff;
            end
         end
         // negate the top entry under the selected condition
         S_NEG_RD: state_in = S_NEG_W;
         S_NEG_W: begin
            if (neg_go) begin
               moves_in = moves_inc;
            end
            state_in = ret_ff;
         end
         // emit the sorted stack, top first
         S_OUT_RD: state_in = S_OUT_SEND;
         S_OUT_SEND: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_a_ff;
            if (HGT_W'(idx_ff) == height_ff - HGT_W'(1)) begin
               rsp_moves_in = moves_ff;
               rsp_final_in = 1'b1;
               height_in    = '0;
               moves_in     = '0;
               state_in     = S_IDLE;
            end else begin
               rsp_moves_in = '0;
               rsp_final_in = 1'b0;
               idx_in       = idx_ff + IDX_W'(1);
               state_in     = S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         height_ff    <= '0;
         moves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_final_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         height_ff    <= height_in;
         moves_ff     <= moves_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_final_ff <= rsp_final_in;
      end
      ret_ff       <= ret_in;
      neg_mode_ff  <= neg_mode_in;
      h_ff         <= h_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_mag_ff  <= best_mag_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_value_ff <= rsp_value_in;
      rsp_moves_ff <= rsp_moves_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_move_total   = rsp_moves_ff;
   assign rsp_is_final_out = rsp_valid_ff && rsp_final_ff;

   // every emitted entry is burnt side down
   a_rsp_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_sorted_value[VAL_W-1])
      else $error("negative entry emitted");

   // the move count only rides on the last entry
   a_rsp_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_final_out) |-> (rsp_move_total == '0))
      else $error("move count on a non-final entry");

   // the stack is empty again once the last entry is out
   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_final_out) |-> (height_ff == '0) && !busy)
      else $error("stack not cleared after last entry");

   // a final transfer starts the sort
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_final) |=> busy)
      else $error("final transfer did not start the sort");

endmodule

// ===== dv/tb_burnt_pancake_sorter.sv =====
// ----------------------------------------------------------------------------
// tb_burnt_pancake_sorter
// self-checking bench for the burnt pancake sorter: a short table of directed
// stacks, then random stacks of random depth, some past the stack limit, each
// output entry checked against a typed row or an in-bench sort of the stack
// ----------------------------------------------------------------------------
module tb_burnt_pancake_sorter;
   timeunit 1ns;
   timeprecision 1ps;

   import bps_pkg::*;

   localparam int RANDOM_ITEMS   = 180;
   localparam int STALL_LIMIT    = 40000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int REPORT_LIMIT   = 10;

   // one row of the directed table; typed rows are one-entry stacks
   typedef struct {
      logic [VAL_W-1:0]  value;
      logic              closes_stack;
      bit                has_typed;
      logic [VAL_W-1:0]  typed_value;
      logic [MOVE_W-1:0] typed_moves;
   } directed_row_type;

   // one entry of the sorted stack as it should leave the block
   typedef struct {
      logic [VAL_W-1:0]  value;
      logic [MOVE_W-1:0] moves;
      logic              last;
   } sorted_entry_type;

   // value mixes for random stacks
   typedef enum int {MIX_FULL, MIX_TIES, MIX_EXTREME} value_mix_type;

   localparam int DIRECTED_ROWS = 22;
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // single pancakes with results read off directly
      '{16'sd5,      1'b1, 1'b1, 16'sd5,     8'd0},
      '{-16'sd5,     1'b1, 1'b1, 16'sd5,     8'd1},
      '{16'sh8000,   1'b1, 1'b1, 16'sd32767, 8'd1},   // most negative code
      '{16'sd32767,  1'b1, 1'b1, 16'sd32767, 8'd0},
      '{16'sd0,      1'b1, 1'b1, 16'sd0,     8'd0},
      '{-16'sd32767, 1'b1, 1'b1, 16'sd32767, 8'd1},
      // mixed burnt sides
      '{-16'sd3,     1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd1,      1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd2,      1'b1, 1'b0, 16'sd0,     8'd0},
      // equal magnitudes, deepest wins
      '{16'sd4,      1'b0, 1'b0, 16'sd0,     8'd0},
      '{-16'sd4,     1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd4,      1'b1, 1'b0, 16'sd0,     8'd0},
      // already sorted
      '{16'sd1,      1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd2,      1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd3,      1'b1, 1'b0, 16'sd0,     8'd0},
      // reverse order, all burnt side up
      '{-16'sd3,     1'b0, 1'b0, 16'sd0,     8'd0},
      '{-16'sd2,     1'b0, 1'b0, 16'sd0,     8'd0},
      '{-16'sd1,     1'b1, 1'b0, 16'sd0,     8'd0},
      // extremes in one stack
      '{16'sh8000,   1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd32767,  1'b0, 1'b0, 16'sd0,     8'd0},
      '{-16'sd1,     1'b0, 1'b0, 16'sd0,     8'd0},
      '{16'sd0,      1'b1, 1'b0, 16'sd0,     8'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [VAL_W-1:0]  req_pancake_value = '0;
   logic              req_is_final = 1'b0;
   logic              rsp_valid;
   logic [VAL_W-1:0]  rsp_sorted_value;
   logic [MOVE_W-1:0] rsp_move_total;
   logic              rsp_is_final_out;

   // predicted stack and move count
   logic signed [VAL_W-1:0] held [MAX_DEPTH];
   int                      held_count = 0;
   logic [MOVE_W-1:0]       flip_total = '0;

   sorted_entry_type expected_stack_out [$];
   int               mismatch_count = 0;
   int               items_sent = 0;
   int               stall_cycles = 0;

   burnt_pancake_sorter dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pancake_value (req_pancake_value),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_move_total    (rsp_move_total),
      .rsp_is_final_out  (rsp_is_final_out)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   function automatic logic [VAL_W-1:0] pancake_size(logic signed [VAL_W-1:0] v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void bump_flips();
      if (flip_total < MOVE_LIMIT)
         flip_total++;
   endfunction

   // reverse the top k+1 pancakes and turn each over
   function automatic void flip_prefix(int k);
      logic signed [VAL_W-1:0] t;
      int lo;
      int hi;
      lo = 0;
      hi = k;
      while (lo < hi) begin
         t        = held[lo];
         held[lo] = held[hi];
         held[hi] = t;
         lo++;
         hi--;
      end
      for (int i = 0; i <= k; i++)
         held[i] = -held[i];
      bump_flips();
   endfunction

   function automatic void burn_top();
      held[0] = -held[0];
      bump_flips();
   endfunction

   // largest magnitude among the top h, ties to the deepest
   function automatic int find_largest_deepest(int h);
      int best;
      best = 0;
      for (int i = 0; i < h; i++)
         if (pancake_size(held[best]) <= pancake_size(held[i]))
            best = i;
      return best;
   endfunction

   function automatic void sort_held_stack();
      int n;
      int m;
      n = held_count;
      // bring each largest pancake burnt side up to the top, then down to its place
      for (int h = n; h > 1; h--) begin
         m = find_largest_deepest(h);
         if (m != h - 1) begin
            if (m != 0)
               flip_prefix(m);
            if (held[0] > 0)
               burn_top();
            flip_prefix(h - 1);
         end
      end
      // turn over every pancake still burnt side up
      for (int i = n - 1; i > 0; i--) begin
         if (held[i] < 0) begin
            flip_prefix(i);
            burn_top();
            flip_prefix(i);
         end
      end
      if (n > 0 && held[0] < 0)
         burn_top();
   endfunction

   // one accepted transfer: load, and on the last pancake sort and queue the stack
   function automatic void predict_transfer(logic [VAL_W-1:0] raw, logic closes);
      logic signed [VAL_W-1:0] v;
      sorted_entry_type e;
      v = (raw == VAL_MOST_NEG) ? VAL_LEAST_NEG_SAFE : raw;
      if (held_count < MAX_DEPTH) begin
         held[held_count] = v;
         held_count++;
      end
      if (closes) begin
         flip_total = '0;
         sort_held_stack();
         for (int i = 0; i < held_count; i++) begin
            e.last  = (i + 1 == held_count);
            e.value = held[i];
            e.moves = e.last ? flip_total : '0;
            expected_stack_out.push_back(e);
         end
         held_count = 0;
         flip_total = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // sender idling: light, then heavy, then none
   function automatic int sender_idle_pct();
      if (items_sent < 80)
         return 8;
      else if (items_sent < 160)
         return 65;
      return 0;
   endfunction

   function automatic logic [VAL_W-1:0] random_pancake(value_mix_type mix);
      int s;
      case (mix)
         MIX_TIES: begin
            s = int'($urandom_range(8)) - 4;
            return s[VAL_W-1:0];
         end
         MIX_EXTREME: begin
            case ($urandom_range(4))
               0: return VAL_MOST_NEG;
               1: return VAL_LEAST_NEG_SAFE;
               2: return 16'h7fff;
               3: return 16'h0000;
               default: return VAL_W'($urandom_range(65535));
            endcase
         end
         default: return VAL_W'($urandom_range(65535));
      endcase
   endfunction

   // drive one pancake and hold it until the transfer happens
   task automatic send_pancake(logic [VAL_W-1:0] v, logic closes);
      while ($urandom_range(99) < sender_idle_pct()) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_pancake_value <= v;
      req_is_final      <= closes;
      do
         @(posedge clock);
      while (busy);
      items_sent++;
   endtask

   initial begin
      int len;
      value_mix_type mix;
      logic [VAL_W-1:0] v;
      sorted_entry_type e;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_pancake(directed_rows[r].value, directed_rows[r].closes_stack);
         if (directed_rows[r].has_typed) begin
            e.value = directed_rows[r].typed_value;
            e.moves = directed_rows[r].typed_moves;
            e.last  = 1'b1;
            expected_stack_out.push_back(e);
         end else begin
            predict_transfer(directed_rows[r].value, directed_rows[r].closes_stack);
         end
      end

      // random stacks, about one in ten deeper than the stack holds
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(MAX_DEPTH + 4, MAX_DEPTH + 1)
                                        : $urandom_range(MAX_DEPTH, 1);
         mix = value_mix_type'($urandom_range(2));
         for (int k = 0; k < len; k++) begin
            v = random_pancake(mix);
            send_pancake(v, k == len - 1);
            predict_transfer(v, k == len - 1);
         end
      end
      start <= 1'b0;

      // drain, then watch for stray results
      while (expected_stack_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_stack_out.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   // each strobed result against the oldest expected entry
   always @(posedge clock) begin
      sorted_entry_type e;
      if (!reset && rsp_valid) begin
         if (expected_stack_out.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: value %0d moves %0d last %0b",
                        $signed(rsp_sorted_value), rsp_move_total, rsp_is_final_out);
         end else begin
            e = expected_stack_out.pop_front();
            if (rsp_sorted_value !== e.value || rsp_move_total !== e.moves ||
                rsp_is_final_out !== e.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected value %0d moves %0d last %0b, got %0d %0d %0b",
                           $signed(e.value), e.moves, e.last,
                           $signed(rsp_sorted_value), rsp_move_total, rsp_is_final_out);
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
hdl/bps_pkg.sv
hdl/burnt_pancake_sorter.sv
dv/tb_burnt_pancake_sorter.sv
